// File: rtl/core/fnse_pkg.sv
// Shared types, widths and calibration tables of the needle shape estimator.
// Used by the top level, the fit engine and the port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fnse_pkg;

    localparam int GRATING_COUNT = 12;
    localparam int GIDX_W        = $clog2(GRATING_COUNT);
    localparam int IDX_W         = 4;
    localparam int WL_W          = 31;
    localparam int CI_W          = 3;
    localparam int ACC_W         = 48;
    localparam int K_W           = 32;   // Q2.29 constants
    localparam int DELTA_W       = 32;
    localparam int PROD_W        = 54;   // delta * calibration, LSB 2^-49
    localparam int PROD_SHIFT    = 9;
    localparam int SECT_N        = 3;
    localparam int ROW_N         = 3;
    localparam int SECT_W        = 2;
    localparam int CURV_LO_W     = 24;
    localparam int FIT_OPD_W     = ACC_W - CURV_LO_W + 1;
    localparam int FIT_PROD_W    = 57;
    localparam int FIT_SUM_W     = 81;   // exact fit sum, LSB 2^-69
    localparam int FIT_SHIFT     = 29;
    localparam int FIT_RND_W     = 52;
    localparam int STEP_W        = 3;

    localparam logic [IDX_W:0] GRATING_LIMIT = (IDX_W + 1)'(GRATING_COUNT);

    localparam logic OP_BASELINE = 1'b0;
    localparam logic OP_MEASURE  = 1'b1;

    localparam logic [IDX_W-1:0]  FRAME_END_IDX = 4'd11;
    localparam logic [CI_W-1:0]   COEFF_FIRST   = 3'd0;
    localparam logic [CI_W-1:0]   COEFF_YZ      = 3'd3;
    localparam logic [CI_W-1:0]   COEFF_LAST    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_FIRST    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LAST     = 3'd5;

    localparam logic signed [PROD_W-1:0]    PROD_RND = 54'sd256;
    localparam logic signed [FIT_SUM_W-1:0] FIT_RND  = 81'sh10000000;

    localparam logic signed [63:0] ACC_MAX64 = 64'sh00007FFFFFFFFFFF;
    localparam logic signed [63:0] ACC_MIN64 = 64'shFFFF800000000000;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] grating_index;
        logic [WL_W-1:0]  wavelength;
    } t_in_item;

    typedef struct packed {
        logic [CI_W-1:0]          coeff_index;
        logic signed [ACC_W-1:0]  coeff_value;
        logic                     last;
    } t_out_item;

    // one accumulator row: both planes of one section
    typedef struct packed {
        logic signed [ACC_W-1:0] xz;
        logic signed [ACC_W-1:0] yz;
    } t_acc_row;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_fit_res;

    typedef struct packed {
        logic              used;
        logic [SECT_W-1:0] sect;
        logic [SECT_W-1:0] row;
    } t_gmap;

    localparam longint P15 = 64'sd30517578125;

    // round(m * 1e-15 * 2^29), elaboration only
    function automatic logic signed [K_W-1:0] qp(input longint m, input logic neg);
        longint v;
        v = (m / P15) * 64'sd16384 + ((m % P15) * 64'sd16384 + P15 / 2) / P15;
        if (neg) begin
            v = -v;
        end
        return K_W'(v);
    endfunction

    localparam logic signed [K_W-1:0] CAL_XZ [SECT_N][ROW_N] = '{
        '{qp(64'sd748867336927, 1'b1), qp(64'sd149139340337, 1'b0),
          qp(64'sd1976798053222, 1'b1)},
        '{qp(64'sd873030745682, 1'b1), qp(64'sd1842941061259, 1'b0),
          qp(64'sd3619990771172, 1'b1)},
        '{qp(64'sd1413614466484, 1'b1), qp(64'sd261312453896, 1'b0),
          qp(64'sd1099139334677, 1'b0)}};

    localparam logic signed [K_W-1:0] CAL_YZ [SECT_N][ROW_N] = '{
        '{qp(64'sd1068881969116, 1'b0), qp(64'sd1503803740640, 1'b0),
          qp(64'sd365319953008, 1'b0)},
        '{qp(64'sd2173139599615, 1'b0), qp(64'sd594529565956, 1'b1),
          qp(64'sd367250476008, 1'b0)},
        '{qp(64'sd1629045053891, 1'b1), qp(64'sd1086421100232, 1'b1),
          qp(64'sd1165117978684, 1'b1)}};

    localparam logic signed [K_W-1:0] PINV [ROW_N][SECT_N] = '{
        '{qp(64'sd196670987170, 1'b0), qp(64'sd185506596030, 1'b1),
          qp(64'sd215754756108, 1'b1)},
        '{qp(64'sd40712424136224, 1'b1), qp(64'sd29143140319940, 1'b0),
          qp(64'sd41572491743759, 1'b0)},
        '{qp(64'sd1808653477078151, 1'b0), qp(64'sd407769396371889, 1'b1),
          qp(64'sd1188711386659099, 1'b1)}};

    // section and row of each grating; 5, 8, 10 and above 11 feed nothing
    function automatic t_gmap grating_map(input logic [IDX_W-1:0] idx);
        t_gmap m;
        m = '{used: 1'b1, sect: 2'd0, row: 2'd0};
        case (idx)
            4'd0:    m = '{used: 1'b1, sect: 2'd0, row: 2'd0};
            4'd1:    m = '{used: 1'b1, sect: 2'd1, row: 2'd0};
            4'd2:    m = '{used: 1'b1, sect: 2'd0, row: 2'd1};
            4'd3:    m = '{used: 1'b1, sect: 2'd1, row: 2'd1};
            4'd4:    m = '{used: 1'b1, sect: 2'd0, row: 2'd2};
            4'd6:    m = '{used: 1'b1, sect: 2'd1, row: 2'd2};
            4'd7:    m = '{used: 1'b1, sect: 2'd2, row: 2'd0};
            4'd9:    m = '{used: 1'b1, sect: 2'd2, row: 2'd1};
            4'd11:   m = '{used: 1'b1, sect: 2'd2, row: 2'd2};
            default: m = '{used: 1'b0, sect: 2'd0, row: 2'd0};
        endcase
        return m;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [63:0] x);
        logic signed [ACC_W-1:0] r;
        if (x > ACC_MAX64) begin
            r = ACC_MAX64[ACC_W-1:0];
        end else if (x < ACC_MIN64) begin
            r = ACC_MIN64[ACC_W-1:0];
        end else begin
            r = x[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fnse_fit.sv
// Frame-end fit engine: pseudo-inverse times curvatures, one partial product a cycle while a coefficient is issued.
// Reads accumulator rows through the top level's memory port; uses fnse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnse_fit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  fnse_pkg::t_acc_row            i_curv,
    input  logic                          i_curv_vld,
    input  logic                          i_out_free,
    output logic [fnse_pkg::SECT_W-1:0]   o_raddr,
    output fnse_pkg::t_fit_res            o_res
);

    logic                                    r_iss;
    logic [fnse_pkg::CI_W-1:0]               r_k;
    logic [fnse_pkg::STEP_W-1:0]             r_step;

    logic                                    r_p1_vld;
    logic [fnse_pkg::CI_W-1:0]               r_p1_k;
    logic [fnse_pkg::SECT_W-1:0]             r_p1_j;
    logic                                    r_p1_h;
    logic                                    r_p1_first;
    logic                                    r_p1_last;

    logic                                    r_p2_vld;
    logic signed [fnse_pkg::FIT_PROD_W-1:0]  r_p2_prod;
    logic                                    r_p2_h;
    logic                                    r_p2_first;
    logic                                    r_p2_last;
    logic [fnse_pkg::CI_W-1:0]               r_p2_k;

    logic signed [fnse_pkg::FIT_SUM_W-1:0]   r_sum;
    logic                                    r_p3_vld;
    logic [fnse_pkg::CI_W-1:0]               r_p3_k;

    logic signed [fnse_pkg::ACC_W-1:0]       curv;
    logic signed [fnse_pkg::FIT_OPD_W-1:0]   opd;
    logic [fnse_pkg::SECT_W-1:0]             kmod;
    logic signed [fnse_pkg::K_W-1:0]         w;
    logic signed [fnse_pkg::FIT_PROD_W-1:0]  mul;
    logic signed [fnse_pkg::FIT_SUM_W-1:0]   term;
    logic signed [fnse_pkg::FIT_SUM_W-1:0]   rnd;
    logic                                    res_fire;

    assign o_raddr = r_step[fnse_pkg::STEP_W-1:1];

    // pick plane and half of the curvature, then one partial product
    always_comb begin
        if (!i_curv_vld) begin
            curv = '0;
        end else if (r_p1_k < fnse_pkg::COEFF_YZ) begin
            curv = i_curv.xz;
        end else begin
            curv = i_curv.yz;
        end
        if (r_p1_h) begin
            opd = {curv[fnse_pkg::ACC_W-1], curv[fnse_pkg::ACC_W-1:fnse_pkg::CURV_LO_W]};
        end else begin
            opd = {1'b0, curv[fnse_pkg::CURV_LO_W-1:0]};
        end
        if (r_p1_k < fnse_pkg::COEFF_YZ) begin
            kmod = r_p1_k[fnse_pkg::SECT_W-1:0];
        end else begin
            kmod = fnse_pkg::SECT_W'(r_p1_k - fnse_pkg::COEFF_YZ);
        end
        w = fnse_pkg::PINV[kmod][r_p1_j];
    end

    assign mul  = opd * w;
    assign term = r_p2_h ? (fnse_pkg::FIT_SUM_W'(r_p2_prod) <<< fnse_pkg::CURV_LO_W)
                         : fnse_pkg::FIT_SUM_W'(r_p2_prod);
    assign rnd  = (r_sum + fnse_pkg::FIT_RND) >>> fnse_pkg::FIT_SHIFT;

    assign res_fire                = r_p3_vld && i_out_free;
    assign o_res.valid             = r_p3_vld;
    assign o_res.item.coeff_index  = r_p3_k;
    assign o_res.item.coeff_value  =
        fnse_pkg::sat_acc(64'(signed'(rnd[fnse_pkg::FIT_RND_W-1:0])));
    assign o_res.item.last         = (r_p3_k == fnse_pkg::COEFF_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss    <= 1'b0;
            r_k      <= fnse_pkg::COEFF_FIRST;
            r_step   <= fnse_pkg::STEP_FIRST;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            if (i_start) begin
                r_iss  <= 1'b1;
                r_k    <= fnse_pkg::COEFF_FIRST;
                r_step <= fnse_pkg::STEP_FIRST;
            end else if (res_fire && (r_k != fnse_pkg::COEFF_LAST)) begin
                // pipeline is drained: start the next coefficient
                r_iss  <= 1'b1;
                r_k    <= r_k + 1'b1;
                r_step <= fnse_pkg::STEP_FIRST;
            end else if (r_iss) begin
                r_step <= r_step + 1'b1;
                if (r_step == fnse_pkg::STEP_LAST) begin
                    r_iss <= 1'b0;
                end
            end
            r_p1_vld <= r_iss;
            r_p2_vld <= r_p1_vld;
            if (r_p2_vld && r_p2_last) begin
                r_p3_vld <= 1'b1;
            end else if (res_fire) begin
                r_p3_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_k     <= r_k;
        r_p1_j     <= r_step[fnse_pkg::STEP_W-1:1];
        r_p1_h     <= r_step[0];
        r_p1_first <= (r_step == fnse_pkg::STEP_FIRST);
        r_p1_last  <= (r_step == fnse_pkg::STEP_LAST);

        r_p2_prod  <= mul;
        r_p2_h     <= r_p1_h;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_k     <= r_p1_k;

        if (r_p2_vld) begin
            r_sum <= r_p2_first ? term : r_sum + term;
        end
        if (r_p2_vld && r_p2_last) begin
            r_p3_k <= r_p2_k;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fbg_needle_shape_estimator.sv
// Needle shape estimator: baseline store, curvature accumulation and frame-end fit.
// Uses fnse_pkg and fnse_fit.
//
// Items arrive one grating wavelength per beat. A baseline beat, a beat for an
// out-of-range index and a measure beat for an unused grating are taken without
// leaving the idle state. A measure beat for a used grating goes read, multiply,
// then add-and-write-back against the three-row accumulator memory, and the next
// beat is taken in the add-and-write-back state; a following beat that hits the
// row being written gets the new value forwarded. A measure beat for grating 11
// then starts the fit: each of the six coefficients takes six passes through one
// 25x32 multiplier plus three pipeline stages, and waits while the output side
// stalls. No input beat is taken during the fit. Results leave through an output
// register, so the next frame's beats are taken while the last coefficient still
// waits. Both memories come out of reset cleared by valid bits.
`timescale 1ns / 1ps
`default_nettype none

module fbg_needle_shape_estimator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fnse_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fnse_pkg::t_out_item  o_out
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_FIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // baseline store
    logic [fnse_pkg::WL_W-1:0]          r_base_mem [fnse_pkg::GRATING_COUNT];
    logic [fnse_pkg::GRATING_COUNT-1:0] r_base_vld;
    logic [fnse_pkg::WL_W-1:0]          r_base_rd;
    logic                               r_base_rd_vld;

    // accumulator store, one row per section
    fnse_pkg::t_acc_row                 r_acc_mem [fnse_pkg::SECT_N];
    logic [fnse_pkg::SECT_N-1:0]        r_acc_vld;
    fnse_pkg::t_acc_row                 r_acc_rd;
    logic                               r_acc_rd_vld;
    fnse_pkg::t_acc_row                 r_fwd;
    logic                               r_fwd_hit;

    // item in flight
    logic [fnse_pkg::WL_W-1:0]          r_wl;
    logic [fnse_pkg::SECT_W-1:0]        r_sect;
    logic [fnse_pkg::SECT_W-1:0]        r_row;
    logic                               r_end;
    logic signed [fnse_pkg::PROD_W-1:0] r_prod_xz;
    logic signed [fnse_pkg::PROD_W-1:0] r_prod_yz;
    fnse_pkg::t_acc_row                 r_acc_cur;

    logic                               r_out_vld;
    fnse_pkg::t_out_item                r_out;

    logic                               in_fire;
    logic                               in_range;
    fnse_pkg::t_gmap                    in_map;
    logic [fnse_pkg::GIDX_W-1:0]        in_addr;
    logic                               base_wr;
    logic                               go_mul;
    logic [fnse_pkg::SECT_W-1:0]        acc_raddr;
    logic [fnse_pkg::WL_W-1:0]          base;
    logic signed [fnse_pkg::DELTA_W-1:0] delta;
    logic signed [63:0]                 mul_xz;
    logic signed [63:0]                 mul_yz;
    fnse_pkg::t_acc_row                 acc_cur;
    logic signed [fnse_pkg::PROD_W-1:0] rnd_xz;
    logic signed [fnse_pkg::PROD_W-1:0] rnd_yz;
    logic signed [fnse_pkg::ACC_W:0]    sum_xz;
    logic signed [fnse_pkg::ACC_W:0]    sum_yz;
    fnse_pkg::t_acc_row                 acc_wdata;
    logic                               fit_start;
    logic                               out_free;
    logic [fnse_pkg::SECT_W-1:0]        fit_raddr;
    fnse_pkg::t_fit_res                 fit_res;
    logic                               fit_fire;
    logic                               fit_done;

    assign o_in_ready = (r_state == ST_IDLE) || ((r_state == ST_ADD) && !r_end);
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_range   = {1'b0, i_in.grating_index} < fnse_pkg::GRATING_LIMIT;
    assign in_map     = fnse_pkg::grating_map(i_in.grating_index);
    assign in_addr    = i_in.grating_index[fnse_pkg::GIDX_W-1:0];
    assign base_wr    = in_fire && in_range && (i_in.opcode == fnse_pkg::OP_BASELINE);
    assign go_mul     = in_fire && in_range && (i_in.opcode == fnse_pkg::OP_MEASURE)
                        && in_map.used;
    assign acc_raddr  = (r_state == ST_FIT) ? fit_raddr : in_map.sect;

    // multiply stage
    assign base    = r_base_rd_vld ? r_base_rd : '0;
    assign delta   = signed'({1'b0, r_wl}) - signed'({1'b0, base});
    assign mul_xz  = delta * fnse_pkg::CAL_XZ[r_sect][r_row];
    assign mul_yz  = delta * fnse_pkg::CAL_YZ[r_sect][r_row];
    assign acc_cur = r_fwd_hit ? r_fwd : (r_acc_rd_vld ? r_acc_rd : '0);

    // add stage: round to 2^-40, accumulate, saturate
    assign rnd_xz  = (r_prod_xz + fnse_pkg::PROD_RND) >>> fnse_pkg::PROD_SHIFT;
    assign rnd_yz  = (r_prod_yz + fnse_pkg::PROD_RND) >>> fnse_pkg::PROD_SHIFT;
    assign sum_xz  = (fnse_pkg::ACC_W + 1)'(r_acc_cur.xz) + rnd_xz[fnse_pkg::ACC_W:0];
    assign sum_yz  = (fnse_pkg::ACC_W + 1)'(r_acc_cur.yz) + rnd_yz[fnse_pkg::ACC_W:0];
    assign acc_wdata.xz = fnse_pkg::sat_acc(64'(sum_xz));
    assign acc_wdata.yz = fnse_pkg::sat_acc(64'(sum_yz));

    assign fit_start = (r_state == ST_ADD) && r_end;
    assign out_free  = !r_out_vld || i_out_ready;
    assign fit_fire  = fit_res.valid && out_free;
    assign fit_done  = fit_fire && fit_res.item.last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (go_mul) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (r_end) begin
                    n_state = ST_FIT;
                end else if (go_mul) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIT: begin
                if (fit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_base_vld <= '0;
            r_acc_vld  <= '0;
            r_fwd_hit  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (base_wr) begin
                r_base_vld[in_addr] <= 1'b1;
            end
            if (r_state == ST_ADD) begin
                r_acc_vld[r_sect] <= 1'b1;
            end else if (fit_done) begin
                // drop the whole frame at once
                r_acc_vld <= '0;
            end
            r_fwd_hit <= go_mul && (r_state == ST_ADD) && (in_map.sect == r_sect);
            if (fit_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // memories and payload
    always_ff @(posedge i_clk) begin
        if (base_wr) begin
            r_base_mem[in_addr] <= i_in.wavelength;
        end
        r_base_rd     <= r_base_mem[in_addr];
        r_base_rd_vld <= r_base_vld[in_addr];

        if (r_state == ST_ADD) begin
            r_acc_mem[r_sect] <= acc_wdata;
            r_fwd             <= acc_wdata;
        end
        r_acc_rd     <= r_acc_mem[acc_raddr];
        r_acc_rd_vld <= r_acc_vld[acc_raddr];

        if (go_mul) begin
            r_wl   <= i_in.wavelength;
            r_sect <= in_map.sect;
            r_row  <= in_map.row;
            r_end  <= (i_in.grating_index == fnse_pkg::FRAME_END_IDX);
        end
        if (r_state == ST_MUL) begin
            r_prod_xz <= mul_xz[fnse_pkg::PROD_W-1:0];
            r_prod_yz <= mul_yz[fnse_pkg::PROD_W-1:0];
            r_acc_cur <= acc_cur;
        end
        if (fit_fire) begin
            r_out <= fit_res.item;
        end
    end

    fnse_fit u_fit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (fit_start),
        .i_curv     (r_acc_rd),
        .i_curv_vld (r_acc_rd_vld),
        .i_out_free (out_free),
        .o_raddr    (fit_raddr),
        .o_res      (fit_res)
    );

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: rtl/core/fnse_chk.sv
// Port-level checker for the needle shape estimator, bound to the top level.
// Uses fnse_pkg for the payload types and the last coefficient index.
`timescale 1ns / 1ps
`default_nettype none

module fnse_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input fnse_pkg::t_in_item   i_in,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input fnse_pkg::t_out_item  o_out
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // last flags exactly the sixth coefficient
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last == (o_out.coeff_index == fnse_pkg::COEFF_LAST)))
        else $error("last flag does not match coefficient index");

    // no input is taken while a frame is still being emitted
    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> !o_in_ready)
        else $error("input ready in the middle of a frame");

endmodule

bind fbg_needle_shape_estimator fnse_chk u_fnse_chk (.*);

`default_nettype wire
